// ----- src/v3alu_pkg.sv -----
// Shared types, constants and helpers for the three-component vector unit.
// No dependencies; every other file in src but v3alu_dly imports this package.
package v3alu_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS     = 16;
   localparam int TOL_BITS      = 31;
   localparam int PROD_BITS     = 2 * WORD_BITS;
   localparam int ACC_BITS      = 2 * WORD_BITS + 2;
   localparam int MAG_BITS      = WORD_BITS + 1;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int SQRT_LAT      = WORD_BITS + 1;
   localparam int DIV_LAT       = WORD_BITS + 1;
   localparam int TOTAL_LAT     = 2 * WORD_BITS + 6;

   localparam logic [TOL_BITS-1:0] TOL_RESET     = TOL_BITS'(1);
   localparam logic [0:0]          CSR_TOL_INDEX = 1'b0;

   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

   typedef enum logic [3:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_ADD_S = 4'd2,
      OP_SUB_S = 4'd3,
      OP_MUL_S = 4'd4,
      OP_DIV_S = 4'd5,
      OP_DOT   = 4'd6,
      OP_CROSS = 4'd7,
      OP_MAG   = 4'd8,
      OP_NORM  = 4'd9,
      OP_EQUAL = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] val;
      logic                 ov;
   } sat_type;

   // Item context that rides alongside the long arithmetic chains
   typedef struct packed {
      op_type                    op;
      logic [2:0][WORD_BITS-1:0] a;
      logic [WORD_BITS-1:0]      s;
      logic [2:0][WORD_BITS-1:0] vec;
      logic [WORD_BITS-1:0]      scal;
      logic                      eq;
      logic                      ov;
      logic                      mag_zero;
   } side_type;

   // Clamp a wide signed value to the word range
   function automatic sat_type sat_acc(input logic signed [ACC_BITS-1:0] v);
      sat_type res;
      res.ov  = 1'b0;
      res.val = v[WORD_BITS-1:0];
      if (v[ACC_BITS-1:WORD_BITS-1] != {(ACC_BITS-WORD_BITS+1){v[ACC_BITS-1]}}) begin
         res.ov  = 1'b1;
         res.val = v[ACC_BITS-1] ? WORD_MIN : WORD_MAX;
      end
      return res;
   endfunction

   function automatic logic signed [ACC_BITS-1:0] acc_ext(input logic signed [PROD_BITS-1:0] p);
      return {{(ACC_BITS-PROD_BITS){p[PROD_BITS-1]}}, p};
   endfunction

endpackage

// ----- src/v3alu_dly.sv -----
// Fixed-depth delay line with a valid bit per stage.
// Depends on nothing but its parameters.
module v3alu_dly #(
   parameter int DEPTH = 1,
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff [DEPTH];
   logic [WIDTH-1:0] data_ff  [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < DEPTH; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      data_ff[0] <= in_data;
      for (int k = 1; k < DEPTH; k++) data_ff[k] <= data_ff[k-1];
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

// ----- src/v3alu_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, rounded to nearest.
// Depends on v3alu_pkg.
module v3alu_sqrt
   import v3alu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [PROD_BITS-1:0] in_rad,
   output logic                 out_valid,
   output logic [MAG_BITS-1:0]  out_root
);

   localparam int STEPS    = WORD_BITS;
   localparam int REM_BITS = WORD_BITS + 3;

   logic                 valid_ff [STEPS+1];
   logic [PROD_BITS-1:0] rad_ff   [STEPS+1];
   logic [REM_BITS-1:0]  rem_ff   [STEPS+1];
   logic [WORD_BITS-1:0] root_ff  [STEPS+1];
   logic                 out_valid_ff;
   logic [MAG_BITS-1:0]  out_root_ff;

   // index 0 is the unregistered entry point
   assign valid_ff[0] = in_valid;
   assign rad_ff[0]   = in_rad;
   assign rem_ff[0]   = '0;
   assign root_ff[0]  = '0;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int POS = STEPS - 1 - k;
      logic [REM_BITS-1:0]  rem_sh, trial, rem_in;
      logic [WORD_BITS-1:0] root_in;

      always_comb begin
         rem_sh = {rem_ff[k][REM_BITS-3:0], rad_ff[k][2*POS+1 -: 2]};
         trial  = {1'b0, root_ff[k], 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[k][WORD_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[k][WORD_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[k+1]  <= rad_ff[k];
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
      end
   end

   // round up when the leftover exceeds the floor root
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (rem_ff[STEPS] > REM_BITS'(root_ff[STEPS])) begin
         out_root_ff <= MAG_BITS'(root_ff[STEPS]) + MAG_BITS'(1);
      end else begin
         out_root_ff <= MAG_BITS'(root_ff[STEPS]);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_root  = out_root_ff;

endmodule

// ----- src/v3alu_div.sv -----
// Pipelined fixed-point divider lane: |num| * 2^FRAC / den, rounded half away
// from zero, one quotient bit per stage, saturated output. Depends on v3alu_pkg.
module v3alu_div
   import v3alu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [WORD_BITS-1:0] in_num,
   input  logic [MAG_BITS-1:0]  in_den,
   input  logic                 in_neg,
   output logic                 out_valid,
   output logic [WORD_BITS-1:0] out_val,
   output logic                 out_ov
);

   localparam int NUM_BITS = WORD_BITS + FRAC_BITS + 2;
   localparam int DEN_BITS = WORD_BITS + 2;

   logic                 valid_ff [WORD_BITS+1];
   logic [NUM_BITS-1:0]  rem_ff   [WORD_BITS+1];
   logic [DEN_BITS-1:0]  den_ff   [WORD_BITS+1];
   logic [WORD_BITS-1:0] quo_ff   [WORD_BITS+1];
   logic                 neg_ff   [WORD_BITS+1];
   logic                 big_ff   [WORD_BITS+1];

   logic [NUM_BITS-1:0]  num_in;
   logic [DEN_BITS-1:0]  den_in;
   logic                 big_in;

   // twice the numerator plus the divisor, over twice the divisor
   always_comb begin
      num_in = (NUM_BITS'(in_num) << (FRAC_BITS + 1)) + NUM_BITS'(in_den);
      den_in = {in_den, 1'b0};
      big_in = (num_in >> WORD_BITS) >= NUM_BITS'(den_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= num_in;
      den_ff[0] <= den_in;
      quo_ff[0] <= '0;
      neg_ff[0] <= in_neg;
      big_ff[0] <= big_in;
   end

   for (genvar k = 1; k <= WORD_BITS; k++) begin : g_bit
      localparam int POS = WORD_BITS - k;
      logic                 take;
      logic [NUM_BITS-1:0]  rem_in;
      logic [WORD_BITS-1:0] quo_in;

      always_comb begin
         take   = (rem_ff[k-1] >> POS) >= NUM_BITS'(den_ff[k-1]);
         rem_in = rem_ff[k-1];
         quo_in = quo_ff[k-1];
         if (take) begin
            rem_in      = rem_ff[k-1] - (NUM_BITS'(den_ff[k-1]) << POS);
            quo_in[POS] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_ff[k-1];
         quo_ff[k] <= quo_in;
         neg_ff[k] <= neg_ff[k-1];
         big_ff[k] <= big_ff[k-1];
      end
   end

   // the negative range reaches one further than the positive
   always_comb begin
      out_ov  = 1'b0;
      out_val = neg_ff[WORD_BITS] ? (~quo_ff[WORD_BITS] + WORD_BITS'(1)) : quo_ff[WORD_BITS];
      if (big_ff[WORD_BITS]) begin
         out_ov  = 1'b1;
         out_val = neg_ff[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end else if (!neg_ff[WORD_BITS] && quo_ff[WORD_BITS] > WORD_MAX) begin
         out_ov  = 1'b1;
         out_val = WORD_MAX;
      end else if (neg_ff[WORD_BITS] && quo_ff[WORD_BITS] > WORD_MIN) begin
         out_ov  = 1'b1;
         out_val = WORD_MIN;
      end
   end

   assign out_valid = valid_ff[WORD_BITS];

endmodule

// ----- src/vec3_alu_unit.sv -----
// Three-component Q16.16 vector unit, top level.
// Depends on v3alu_pkg, v3alu_dly, v3alu_sqrt and v3alu_div.
//
// Usage:
//   Command channel: an item transfers at a rising edge with start high and
//   busy low. busy is low whenever reset is low, so one item may enter per
//   cycle, back to back, with no gaps needed.
//   Result channel: rsp_valid marks each result for exactly one cycle; the
//   receiver takes it at the closing edge and cannot hold it off, so nothing
//   in the pipeline ever waits.
//   The delay from the command transfer to rsp_valid is the same for every
//   opcode. Throughput is one item per clock.
//   The latency is set by the square-root chain (one root bit per stage)
//   followed by the divider chain (one quotient bit per stage) that serve
//   the magnitude, normalise and scalar divide operations.
//   Configuration: APB-style, one register (equal_tolerance) at byte 0;
//   the user must write it only while the unit is empty; not enforced.
//   pready is always high. Reset: synchronous; clears every valid bit and
//   loads the tolerance with its reset value. Items in flight are dropped.
module vec3_alu_unit
   import v3alu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [3:0]               req_opcode,
   input  logic [WORD_BITS-1:0]     req_a_x,
   input  logic [WORD_BITS-1:0]     req_a_y,
   input  logic [WORD_BITS-1:0]     req_a_z,
   input  logic [WORD_BITS-1:0]     req_b_x,
   input  logic [WORD_BITS-1:0]     req_b_y,
   input  logic [WORD_BITS-1:0]     req_b_z,
   input  logic [WORD_BITS-1:0]     req_scalar_in,
   output logic                     rsp_valid,
   output logic [WORD_BITS-1:0]     rsp_r_x,
   output logic [WORD_BITS-1:0]     rsp_r_y,
   output logic [WORD_BITS-1:0]     rsp_r_z,
   output logic [WORD_BITS-1:0]     rsp_scalar_out,
   output logic                     rsp_is_equal,
   output logic [1:0]               rsp_status,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int SIDE_BITS = $bits(side_type);

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [TOL_BITS-1:0] tol_ff;
   logic                csr_hit;

   assign csr_hit = (paddr[CSR_ADDR_BITS-1:2] == CSR_TOL_INDEX);
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? {{(CSR_DATA_BITS-TOL_BITS){1'b0}}, tol_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         tol_ff <= pwdata[TOL_BITS-1:0];
      end
   end

   // the pipeline never stalls; hold off commands only during reset
   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // ---------------------------------------------------------------------
   // Stage 1: capture the command
   // ---------------------------------------------------------------------
   logic                      s1_valid_ff;
   op_type                    s1_op_ff;
   logic [2:0][WORD_BITS-1:0] s1_a_ff, s1_b_ff;
   logic [WORD_BITS-1:0]      s1_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff <= op_type'(req_opcode);
      s1_a_ff  <= {req_a_z, req_a_y, req_a_x};
      s1_b_ff  <= {req_b_z, req_b_y, req_b_x};
      s1_s_ff  <= req_scalar_in;
   end

   // ---------------------------------------------------------------------
   // Stage 1 -> 2: add/subtract, tolerance compare, operand select, multiply
   // ---------------------------------------------------------------------
   side_type                  s2_side_in;
   logic [2:0][WORD_BITS-1:0] mul_xp, mul_yp, mul_xq, mul_yq;
   logic signed [PROD_BITS-1:0] s2_p_in [3];
   logic signed [PROD_BITS-1:0] s2_q_in [3];

   always_comb begin : s1_calc
      logic [WORD_BITS:0]   sum, diff, abs_diff;
      logic [WORD_BITS-1:0] opnd;
      logic                 eq_all, sub, addsub;
      s2_side_in    = '0;
      s2_side_in.op = s1_op_ff;
      s2_side_in.a  = s1_a_ff;
      s2_side_in.s  = s1_s_ff;
      eq_all = 1'b1;
      sub    = (s1_op_ff == OP_SUB) || (s1_op_ff == OP_SUB_S);
      addsub = (s1_op_ff == OP_ADD) || (s1_op_ff == OP_SUB) ||
               (s1_op_ff == OP_ADD_S) || (s1_op_ff == OP_SUB_S);
      for (int i = 0; i < 3; i++) begin
         opnd = ((s1_op_ff == OP_ADD) || (s1_op_ff == OP_SUB)) ? s1_b_ff[i] : s1_s_ff;
         if (sub) begin
            sum = {s1_a_ff[i][WORD_BITS-1], s1_a_ff[i]} - {opnd[WORD_BITS-1], opnd};
         end else begin
            sum = {s1_a_ff[i][WORD_BITS-1], s1_a_ff[i]} + {opnd[WORD_BITS-1], opnd};
         end
         diff = {s1_a_ff[i][WORD_BITS-1], s1_a_ff[i]} - {s1_b_ff[i][WORD_BITS-1], s1_b_ff[i]};
         abs_diff = diff[WORD_BITS] ? (~diff + (WORD_BITS+1)'(1)) : diff;
         if (abs_diff >= {{(WORD_BITS+1-TOL_BITS){1'b0}}, tol_ff}) eq_all = 1'b0;
         if (addsub) begin
            if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
               s2_side_in.vec[i] = sum[WORD_BITS] ? WORD_MIN : WORD_MAX;
               s2_side_in.ov     = 1'b1;
            end else begin
               s2_side_in.vec[i] = sum[WORD_BITS-1:0];
            end
         end
      end
      s2_side_in.eq = (s1_op_ff == OP_EQUAL) && eq_all;
   end

   // Operand routing: p lanes serve every product, q lanes the cross terms
   always_comb begin
      mul_xp = s1_a_ff;
      mul_yp = s1_b_ff;
      mul_xq = {s1_a_ff[1], s1_a_ff[0], s1_a_ff[2]};
      mul_yq = {s1_b_ff[0], s1_b_ff[2], s1_b_ff[1]};
      unique case (s1_op_ff)
         OP_MUL_S: begin
            mul_yp = {s1_s_ff, s1_s_ff, s1_s_ff};
         end
         OP_CROSS: begin
            mul_xp = {s1_a_ff[0], s1_a_ff[2], s1_a_ff[1]};
            mul_yp = {s1_b_ff[1], s1_b_ff[0], s1_b_ff[2]};
         end
         OP_MAG, OP_NORM: begin
            mul_yp = s1_a_ff;
         end
         default: begin
            mul_yp = s1_b_ff;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         s2_p_in[i] = $signed(mul_xp[i]) * $signed(mul_yp[i]);
         s2_q_in[i] = $signed(mul_xq[i]) * $signed(mul_yq[i]);
      end
   end

   logic                        s2_valid_ff;
   side_type                    s2_side_ff;
   logic signed [PROD_BITS-1:0] s2_p_ff [3];
   logic signed [PROD_BITS-1:0] s2_q_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_side_ff <= s2_side_in;
      s2_p_ff    <= s2_p_in;
      s2_q_ff    <= s2_q_in;
   end

   // ---------------------------------------------------------------------
   // Stage 2 -> 3: exact sums of products
   // ---------------------------------------------------------------------
   logic signed [ACC_BITS-1:0] s3_lane_in [3];

   always_comb begin
      if ((s2_side_ff.op == OP_DOT) || (s2_side_ff.op == OP_MAG) ||
          (s2_side_ff.op == OP_NORM)) begin
         s3_lane_in[0] = acc_ext(s2_p_ff[0]) + acc_ext(s2_p_ff[1]) + acc_ext(s2_p_ff[2]);
      end else if (s2_side_ff.op == OP_CROSS) begin
         s3_lane_in[0] = acc_ext(s2_p_ff[0]) - acc_ext(s2_q_ff[0]);
      end else begin
         s3_lane_in[0] = acc_ext(s2_p_ff[0]);
      end
      for (int i = 1; i < 3; i++) begin
         if (s2_side_ff.op == OP_CROSS) begin
            s3_lane_in[i] = acc_ext(s2_p_ff[i]) - acc_ext(s2_q_ff[i]);
         end else begin
            s3_lane_in[i] = acc_ext(s2_p_ff[i]);
         end
      end
   end

   logic                       s3_valid_ff;
   side_type                   s3_side_ff;
   logic signed [ACC_BITS-1:0] s3_lane_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_side_ff <= s2_side_ff;
      s3_lane_ff <= s3_lane_in;
   end

   // ---------------------------------------------------------------------
   // Stage 3 -> 4: round half up, saturate products and sums
   // ---------------------------------------------------------------------
   side_type s4_side_in;

   always_comb begin : s3_calc
      logic signed [ACC_BITS-1:0] rnd;
      sat_type                    lim;
      s4_side_in = s3_side_ff;
      for (int i = 0; i < 3; i++) begin
         rnd = (s3_lane_ff[i] + ROUND_HALF) >>> FRAC_BITS;
         lim = sat_acc(rnd);
         if ((s3_side_ff.op == OP_MUL_S) || (s3_side_ff.op == OP_CROSS)) begin
            s4_side_in.vec[i] = lim.val;
            s4_side_in.ov     = s4_side_in.ov | lim.ov;
         end else if ((s3_side_ff.op == OP_DOT) && (i == 0)) begin
            s4_side_in.scal = lim.val;
            s4_side_in.ov   = lim.ov;
         end
      end
   end

   logic     s4_valid_ff;
   side_type s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_side_ff <= s4_side_in;
   end

   // ---------------------------------------------------------------------
   // Square root of the sum of squares; context waits alongside
   // ---------------------------------------------------------------------
   logic                 sq_valid;
   logic [MAG_BITS-1:0]  sq_root;
   logic                 s5_valid;
   logic [SIDE_BITS-1:0] s5_bits;
   side_type             s5_side;

   v3alu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_lane_ff[0][PROD_BITS-1:0]),
      .out_valid (sq_valid),
      .out_root  (sq_root)
   );

   v3alu_dly #(
      .DEPTH (SQRT_LAT - 1),
      .WIDTH (SIDE_BITS)
   ) u_dly_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_data   (s4_side_ff),
      .out_valid (s5_valid),
      .out_data  (s5_bits)
   );

   assign s5_side = side_type'(s5_bits);

   // ---------------------------------------------------------------------
   // Magnitude result and divider operands
   // ---------------------------------------------------------------------
   side_type                  s6_side_in;
   logic [MAG_BITS-1:0]       div_den;
   logic [2:0][WORD_BITS-1:0] div_num;
   logic [2:0]                div_neg;

   always_comb begin
      s6_side_in          = s5_side;
      s6_side_in.mag_zero = (sq_root == '0);
      if (s5_side.op == OP_MAG) begin
         if (sq_root > MAG_BITS'(WORD_MAX)) begin
            s6_side_in.scal = WORD_MAX;
            s6_side_in.ov   = 1'b1;
         end else begin
            s6_side_in.scal = sq_root[WORD_BITS-1:0];
         end
      end
      if (s5_side.op == OP_DIV_S) begin
         div_den = s5_side.s[WORD_BITS-1] ?
                   (~{1'b1, s5_side.s} + MAG_BITS'(1)) : {1'b0, s5_side.s};
      end else begin
         div_den = sq_root;
      end
      for (int i = 0; i < 3; i++) begin
         div_num[i] = s5_side.a[i][WORD_BITS-1] ?
                      (~s5_side.a[i] + WORD_BITS'(1)) : s5_side.a[i];
         div_neg[i] = s5_side.a[i][WORD_BITS-1] ^
                      ((s5_side.op == OP_DIV_S) && s5_side.s[WORD_BITS-1]);
      end
   end

   logic [2:0]                dv_valid;
   logic [2:0][WORD_BITS-1:0] dv_val;
   logic [2:0]                dv_ov;

   for (genvar i = 0; i < 3; i++) begin : g_div
      v3alu_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid),
         .in_num    (div_num[i]),
         .in_den    (div_den),
         .in_neg    (div_neg[i]),
         .out_valid (dv_valid[i]),
         .out_val   (dv_val[i]),
         .out_ov    (dv_ov[i])
      );
   end

   logic                 s7_valid;
   logic [SIDE_BITS-1:0] s7_bits;
   side_type             s7_side;

   v3alu_dly #(
      .DEPTH (DIV_LAT),
      .WIDTH (SIDE_BITS)
   ) u_dly_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_valid),
      .in_data   (s6_side_in),
      .out_valid (s7_valid),
      .out_data  (s7_bits)
   );

   assign s7_side = side_type'(s7_bits);

   // ---------------------------------------------------------------------
   // Final merge: quotients, divide-by-zero, status; register the result
   // ---------------------------------------------------------------------
   logic [2:0][WORD_BITS-1:0] rsp_vec_in;
   logic [1:0]                rsp_status_in;

   always_comb begin : fin_calc
      logic ov, divz;
      rsp_vec_in = s7_side.vec;
      ov         = s7_side.ov;
      divz       = 1'b0;
      if (s7_side.op == OP_DIV_S) begin
         if (s7_side.s == '0) begin
            divz = 1'b1;
            for (int i = 0; i < 3; i++) begin
               if (s7_side.a[i] == '0) begin
                  rsp_vec_in[i] = '0;
               end else begin
                  rsp_vec_in[i] = s7_side.a[i][WORD_BITS-1] ? WORD_MIN : WORD_MAX;
               end
            end
         end else begin
            rsp_vec_in = dv_val;
            ov         = |dv_ov;
         end
      end else if ((s7_side.op == OP_NORM) && !s7_side.mag_zero) begin
         rsp_vec_in = dv_val;
         ov         = |dv_ov;
      end
      priority if (divz) begin
         rsp_status_in = ST_DIVZ;
      end else if (ov) begin
         rsp_status_in = ST_SAT;
      end else begin
         rsp_status_in = ST_OK;
      end
   end

   logic                      rsp_valid_ff;
   logic [2:0][WORD_BITS-1:0] rsp_vec_ff;
   logic [WORD_BITS-1:0]      rsp_scal_ff;
   logic                      rsp_eq_ff;
   logic [1:0]                rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s7_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_vec_ff    <= rsp_vec_in;
      rsp_scal_ff   <= s7_side.scal;
      rsp_eq_ff     <= s7_side.eq;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_r_x        = rsp_vec_ff[0];
   assign rsp_r_y        = rsp_vec_ff[1];
   assign rsp_r_z        = rsp_vec_ff[2];
   assign rsp_scalar_out = rsp_scal_ff;
   assign rsp_is_equal   = rsp_eq_ff;
   assign rsp_status     = rsp_status_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // every transfer comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##TOTAL_LAT rsp_valid)
      else $error("result missing after fixed latency");

   // the divider lanes and the waiting context stay in step
   a_align: assert property (@(posedge clock) disable iff (reset)
      dv_valid[0] == s7_valid)
      else $error("divider and context out of step");

   // a division by zero carries no scalar or equality result
   a_divz: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DIVZ) |-> (rsp_scalar_out == '0 && !rsp_is_equal))
      else $error("stray scalar result on division by zero");

   // an equality hit is clean and leaves the vector at zero
   a_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_equal) |-> (rsp_status == ST_OK && rsp_r_x == '0))
      else $error("equality result with stray fields");

endmodule
